// File: rtl/core/sacfb_pkg.sv
// Shared types and constants for the sample accumulation framebuffer.
`timescale 1ns / 1ps
package sacfb_pkg;

  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned AccBits   = 32;
  localparam int unsigned PixDepth  = MaxWidth * MaxHeight;
  localparam int unsigned PixAw     = $clog2(PixDepth);
  localparam int unsigned ProdBits  = AccBits + 16;
  localparam logic [15:0] ResolveScale = 16'd65533;

  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;

  typedef enum logic [2:0] {
    KIND_SET_ACC   = 3'd0,
    KIND_ADD_ACC   = 3'd1,
    KIND_READ_ACC  = 3'd2,
    KIND_RESOLVE   = 3'd3,
    KIND_READ_REN  = 3'd4,
    KIND_WRITE_REN = 3'd5
  } kind_e;

  typedef logic [AccBits-1:0] acc_t;

  typedef struct packed {
    logic            start;
    logic [15:0]     divisor;
    acc_t [2:0]      acc;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [2:0][7:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/core/sample_accumulation_framebuffer.sv
// Top level: pixel accumulation store with resolve to 8-bit render store.
//
//  channel   | dir | handshake                    | payload
//  s_axis    | in  | tvalid/tready                | tuser kind, tdata pos/color/divisor
//  m_axis    | out | tvalid/tready                | tuser in_frame, tdata acc/8-bit color
//  cfg       | in  | cfg_we_i, no wait            | cfg_idx_i, cfg_data_i
//
// One item at a time; a resolve adds a multiply plus nine divider steps,
// and an item out of frame or of an unknown kind skips the store access.
// After reset a clearing pass writes zero to all 262144 accumulator
// entries, one a cycle; no item is accepted during it.
// The result waits in an output register; the next item is accepted
// meanwhile and finishes once that register is free.
`timescale 1ns / 1ps
module sample_accumulation_framebuffer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [2:0]   s_axis_tuser,   // kind
  input  logic [87:0]  s_axis_tdata,   // pos_x, pos_y, red, green, blue, divisor
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic         m_axis_tuser,   // in_frame
  output logic [119:0] m_axis_tdata,   // acc_red, acc_green, acc_blue, out_red, out_green, out_blue
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [9:0]   cfg_data_i
);
  import sacfb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_IDX, S_RD, S_EX, S_DV, S_FIN} state_e;

  state_e            state_q;
  logic [PixAw:0]    clr_cnt_q;
  logic              clearing;
  logic [9:0]        fw_q, fh_q;
  logic [2:0]        kind_q;
  logic [11:0]       x_q, y_q;
  logic [2:0][15:0]  col_q;
  logic [15:0]       div_q;
  logic [PixAw-1:0]  idx_q;
  logic              inf_q;
  acc_t [2:0]        racc_q;
  logic [2:0][7:0]   rout_q;
  logic              m_valid_q, m_user_q;
  logic [119:0]      m_data_q;

  logic [9:0]        eff_w, eff_h;
  logic              in_frame;
  logic [PixAw-1:0]  idx_d;
  acc_t [2:0]        acc_rd, acc_wd;
  logic [2:0][7:0]   ren_rd, ren_wd;
  logic              acc_we, ren_we, rd_en;
  logic [PixAw-1:0]  acc_waddr;
  div_req_t          dreq;
  div_rsp_t          drsp;

  assign clearing = !clr_cnt_q[PixAw];
  assign eff_w = (fw_q > 10'(MaxWidth)) ? 10'(MaxWidth) : fw_q;
  assign eff_h = (fh_q > 10'(MaxHeight)) ? 10'(MaxHeight) : fh_q;
  assign in_frame = !x_q[11] && !y_q[11] && ({1'b0, x_q[10:0]} < {2'b0, eff_w})
                 && ({1'b0, y_q[10:0]} < {2'b0, eff_h})
                 && (kind_q <= KIND_WRITE_REN);
  assign idx_d = PixAw'(y_q[9:0] * eff_w + {10'b0, x_q[9:0]});

  assign s_axis_tready = (state_q == S_IDLE) && !clearing;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  assign rd_en     = (state_q == S_RD);
  assign acc_we    = clearing || ((state_q == S_EX) &&
                     (kind_q == KIND_SET_ACC || kind_q == KIND_ADD_ACC));
  assign acc_waddr = clearing ? clr_cnt_q[PixAw-1:0] : idx_q;
  assign ren_we    = ((state_q == S_EX) && (kind_q == KIND_WRITE_REN)) ||
                     ((state_q == S_DV) && drsp.done);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [AccBits:0] sum;
      sum = {1'b0, acc_rd[c]} + (AccBits + 1)'(col_q[c]);
      if (clearing) begin
        acc_wd[c] = '0;
      end else if (kind_q == KIND_SET_ACC) begin
        acc_wd[c] = AccBits'(col_q[c]);
      end else begin
        acc_wd[c] = sum[AccBits] ? '1 : sum[AccBits-1:0];
      end
      if (state_q == S_DV) begin
        ren_wd[c] = drsp.quo[c];
      end else begin
        ren_wd[c] = (col_q[c] > 16'd255) ? 8'hFF : col_q[c][7:0];
      end
    end
    dreq.start   = (state_q == S_EX) && (kind_q == KIND_RESOLVE);
    dreq.divisor = div_q;
    dreq.acc     = acc_rd;
  end

  sacfb_ram #(.Width(3 * AccBits), .Depth(PixDepth)) u_acc_ram (
    .clk_i, .we_i(acc_we), .waddr_i(acc_waddr), .wdata_i(acc_wd),
    .re_i(rd_en), .raddr_i(idx_q), .rdata_o(acc_rd)
  );

  sacfb_ram #(.Width(24), .Depth(PixDepth)) u_ren_ram (
    .clk_i, .we_i(ren_we), .waddr_i(idx_q), .wdata_i(ren_wd),
    .re_i(rd_en), .raddr_i(idx_q), .rdata_o(ren_rd)
  );

  sacfb_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      clr_cnt_q <= '0;
      fw_q      <= 10'd512;
      fh_q      <= 10'd512;
      m_valid_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_we_i && cfg_idx_i == RegFrameWidth) begin
        fw_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == RegFrameHeight) begin
        fh_q <= cfg_data_i;
      end
      if (m_valid_q && m_axis_tready && state_q != S_FIN) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind_q  <= s_axis_tuser;
            x_q     <= s_axis_tdata[11:0];
            y_q     <= s_axis_tdata[23:12];
            col_q   <= s_axis_tdata[71:24];
            div_q   <= s_axis_tdata[87:72];
            state_q <= S_IDX;
          end
        end
        S_IDX: begin
          inf_q   <= in_frame;
          idx_q   <= idx_d;
          racc_q  <= '0;
          rout_q  <= '0;
          state_q <= in_frame ? S_RD : S_FIN;
        end
        S_RD: state_q <= S_EX;
        S_EX: begin
          case (kind_q)
            KIND_READ_ACC: racc_q <= acc_rd;
            KIND_READ_REN: rout_q <= ren_rd;
            default: ;
          endcase
          state_q <= (kind_q == KIND_RESOLVE) ? S_DV : S_FIN;
        end
        S_DV: begin
          if (drsp.done) begin
            rout_q  <= drsp.quo;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_user_q  <= inf_q;
            m_data_q  <= {rout_q, 32'(racc_q[2]), 32'(racc_q[1]), 32'(racc_q[0])};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/sacfb_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module sacfb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/core/sacfb_div.sv
// Iterative three-channel resolve divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sacfb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sacfb_pkg::div_req_t req_i,
  output sacfb_pkg::div_rsp_t rsp_o
);
  import sacfb_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_RUN} state_e;

  state_e                     state_q;
  acc_t [2:0]                 acc_q;
  logic [15:0]                div_q;
  logic [2:0][ProdBits-1:0]   rem_q;
  logic [ProdBits-1:0]        dsh_q;
  logic [3:0]                 cnt_q;
  logic [2:0]                 sat_q;
  logic [2:0][7:0]            quo_q;
  logic                       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            acc_q   <= req_i.acc;
            div_q   <= req_i.divisor;
            state_q <= D_MUL;
          end
        end
        D_MUL: begin
          for (int c = 0; c < 3; c++) begin
            rem_q[c] <= acc_q[c] * ResolveScale;
          end
          dsh_q   <= ProdBits'({div_q, 20'b0}) << 8;
          cnt_q   <= 4'd8;
          sat_q   <= '0;
          quo_q   <= '0;
          state_q <= D_RUN;
        end
        D_RUN: begin
          for (int c = 0; c < 3; c++) begin
            if (rem_q[c] >= dsh_q) begin
              if (cnt_q[3]) begin
                sat_q[c] <= 1'b1;
              end else begin
                rem_q[c]            <= rem_q[c] - dsh_q;
                quo_q[c][cnt_q[2:0]] <= 1'b1;
              end
            end
          end
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == 4'd0) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    for (int c = 0; c < 3; c++) begin
      if (div_q == 16'd0) begin
        rsp_o.quo[c] = (acc_q[c] != '0) ? 8'hFF : 8'h00;
      end else begin
        rsp_o.quo[c] = sat_q[c] ? 8'hFF : quo_q[c];
      end
    end
  end

endmodule

// File: rtl/core/sacfb_chk.sv
// Port checker for the sample accumulation framebuffer, bound to the top level.
`timescale 1ns / 1ps
module sacfb_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [2:0]   s_axis_tuser,
  input logic [87:0]  s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic         m_axis_tuser,
  input logic [119:0] m_axis_tdata,
  input logic         cfg_we_i,
  input logic [1:0]   cfg_idx_i,
  input logic [9:0]   cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 120'd0)
    else $error("out-of-frame result not black");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[119:96] != 24'd0 |-> m_axis_tdata[95:0] == 96'd0)
    else $error("accumulator and color both returned");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while busy");

endmodule

bind sample_accumulation_framebuffer sacfb_chk u_sacfb_chk (.*);
